@@ hw/rtl/pva_pkg.sv @@
// Shared types and constants for the polyphonic voice allocator.
// No dependencies.
`timescale 1ns / 1ps
package pva_pkg;

  localparam int unsigned VOICES_DEF = 8;
  localparam int unsigned KEYS = 128;
  localparam logic [15:0] GRACE_RESET = 16'd1440;

  // Event kinds
  localparam logic [2:0] K_NOTE_ON  = 3'd0;
  localparam logic [2:0] K_NOTE_OFF = 3'd1;
  localparam logic [2:0] K_PEDAL    = 3'd2;
  localparam logic [2:0] K_ALL_OFF  = 3'd3;
  localparam logic [2:0] K_ADVANCE  = 3'd4;
  localparam logic [2:0] K_FINISHED = 3'd5;

  // Result actions
  localparam logic [1:0] A_START    = 2'd0;
  localparam logic [1:0] A_RELEASE  = 2'd1;
  localparam logic [1:0] A_HOLD     = 2'd2;
  localparam logic [1:0] A_REL_SUST = 2'd3;

  // Voice modes
  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_PLAY = 2'd1;
  localparam logic [1:0] M_SUST = 2'd2;
  localparam logic [1:0] M_REL  = 2'd3;

  // One event word as carried between front and back
  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  note;
    logic        pedal_down;
    logic [7:0]  unison_count;
    logic [15:0] detune_spread;
    logic [15:0] sample_count;
    logic [2:0]  finished_voice;
  } event_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  voice;
    logic [6:0]  out_note;
    logic        stolen;
    logic [15:0] detune;
    logic        fire_single;
    logic        last;
  } result_t;

endpackage

@@ hw/rtl/pva_front.sv @@
// Front end: accepts event words and queues them for the back end.
// Depends on pva_pkg.
`timescale 1ns / 1ps
module pva_front import pva_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  event_t in_event_i,
  output logic   q_valid_o,
  input  logic   q_ready_i,
  output event_t q_event_o
);

  localparam int unsigned DEPTH = 2;

  event_t     buf_q [DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'(DEPTH));
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_event_o  = buf_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  // two-entry event queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_event_i;
  end

  cnt_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(DEPTH)) else $error("queue overflow");
  push_full_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(DEPTH) && !pop) |=> cnt_q == 2'(DEPTH)) else $error("queue lost word");
  pop_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1 && pop && !push) |=> !q_valid_o) else $error("queue count");

endmodule

@@ hw/rtl/pva_back.sv @@
// Back end: sequencer that walks the voice slots for each event and emits results.
// Also holds the 128-entry held-key map, cleared by a pass after reset and on all off.
// Depends on pva_pkg.
`timescale 1ns / 1ps
module pva_back import pva_pkg::*; #(
  parameter int unsigned VOICES = VOICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  event_t      q_event_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_result_o
);

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned SW = $clog2(VOICES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_KEY, S_SCAN, S_PICK, S_DIV_SET, S_DIV, S_START, S_WAIT, S_NEXT
  } state_e;

  state_e      state_q;
  event_t      ev_q;
  logic [15:0] grace_q, grace_left_q;
  logic [1:0]  mode_q [VOICES];
  logic [6:0]  key_q  [VOICES];
  logic [31:0] age_q  [VOICES];
  logic [31:0] age_ctr_q;
  logic        key_down_q [KEYS];
  logic        kd_q;
  logic [6:0]  clr_q;
  logic        boot_q;
  logic [7:0]  keys_cnt_q;
  logic [VW-1:0] vi_q, best_q;
  logic        found_idle_q;
  logic [31:0] best_age_q;
  logic [SW-1:0] s_q, i_q;
  logic        fire_q;
  logic        has_res_q;
  result_t     res_q, pend_q;
  logic        out_v_q;
  // divider
  logic [23:0] dnum_q;
  logic        dneg_q;
  logic [15:0] dquo_q;
  logic [24:0] drem_q;
  logic [4:0]  dcnt_q;
  logic [8:0]  dden_q;

  logic        last_vi;
  logic        act;
  logic [1:0]  nmode;
  logic [1:0]  acode;
  logic [6:0]  anote;
  logic [24:0] dtrial;
  logic signed [10:0] mult;
  logic [SW-1:0] ucl;
  logic        out_free;
  logic        emit;
  logic        km_we;
  logic [6:0]  km_addr;
  logic        km_wd;

  assign last_vi = (32'(vi_q) == VOICES - 1);
  assign q_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_result_o = res_q;
  assign out_free = !out_v_q || out_ready_i;
  assign dtrial = {drem_q[23:0], dnum_q[23]} - {16'd0, dden_q};
  assign mult = 11'($signed({1'b0, i_q, 1'b0})) - 11'($signed({1'b0, s_q})) + 11'sd1;
  assign ucl = (ev_q.unison_count == 8'd0) ? SW'(1) :
               (32'(ev_q.unison_count) > VOICES) ? SW'(VOICES) : SW'(ev_q.unison_count);

  // scan decision for current slot
  always_comb begin
    act = 1'b0; nmode = mode_q[vi_q]; acode = A_RELEASE; anote = ev_q.note;
    unique case (ev_q.kind)
      K_NOTE_ON: begin
        if ((mode_q[vi_q] == M_PLAY || mode_q[vi_q] == M_SUST) && key_q[vi_q] == ev_q.note) begin
          act = 1'b1; nmode = M_REL;
        end
      end
      K_NOTE_OFF: begin
        if ((mode_q[vi_q] == M_PLAY || mode_q[vi_q] == M_SUST) && key_q[vi_q] == ev_q.note) begin
          if (ev_q.pedal_down) begin
            if (mode_q[vi_q] == M_PLAY) begin
              act = 1'b1; nmode = M_SUST; acode = A_HOLD;
            end
          end else begin
            act = 1'b1; nmode = M_REL;
          end
        end
      end
      K_PEDAL: begin
        if (mode_q[vi_q] == M_SUST) begin
          act = 1'b1; nmode = M_REL; acode = A_REL_SUST; anote = key_q[vi_q];
        end
      end
      K_ALL_OFF: begin
        if (mode_q[vi_q] == M_PLAY || mode_q[vi_q] == M_SUST) begin
          act = 1'b1; nmode = M_REL; anote = key_q[vi_q];
        end
      end
      default: ;
    endcase
  end

  // pending result moves to the output register
  always_comb begin
    emit = 1'b0;
    unique case (state_q)
      S_SCAN:  emit = act && has_res_q;
      S_NEXT:  emit = last_vi && (ev_q.kind != K_NOTE_ON) && has_res_q && out_free;
      S_START: emit = has_res_q && out_free;
      default: ;
    endcase
  end

  // held-key map write port: clearing pass or key update
  always_comb begin
    km_we = 1'b0; km_addr = ev_q.note; km_wd = 1'b0;
    if (state_q == S_CLR) begin
      km_we = 1'b1; km_addr = clr_q;
    end else if (state_q == S_KEY) begin
      if (ev_q.kind == K_NOTE_ON && !kd_q) begin
        km_we = 1'b1; km_wd = 1'b1;
      end else if (ev_q.kind == K_NOTE_OFF && kd_q) begin
        km_we = 1'b1;
      end
    end
  end

  // held-key map, read registered at the accepted note
  always_ff @(posedge clk_i) begin
    if (km_we) key_down_q[km_addr] <= km_wd;
    kd_q <= key_down_q[q_event_i.note];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= 7'd0;
      boot_q <= 1'b1;
      grace_q <= GRACE_RESET;
      grace_left_q <= 16'd0;
      for (int v = 0; v < VOICES; v++) begin
        mode_q[v] <= M_IDLE; key_q[v] <= 7'd0; age_q[v] <= 32'd0;
      end
      age_ctr_q <= 32'd0;
      keys_cnt_q <= 8'd0;
      out_v_q <= 1'b0;
      has_res_q <= 1'b0;
    end else begin
      if (cfg_we_i) grace_q <= cfg_data_i;
      if (emit) begin
        res_q <= result_t'({pend_q[$bits(result_t)-1:1], state_q == S_NEXT});
        out_v_q <= 1'b1;
      end else if (out_ready_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (q_valid_i) begin
          ev_q <= q_event_i;
          vi_q <= '0;
          has_res_q <= 1'b0;
          unique case (q_event_i.kind)
            K_NOTE_ON: begin
              if (keys_cnt_q == 8'd0) begin
                grace_left_q <= grace_q; fire_q <= (grace_q != 16'd0);
              end else fire_q <= (grace_left_q != 16'd0);
              state_q <= S_KEY;
            end
            K_NOTE_OFF: state_q <= S_KEY;
            K_PEDAL: state_q <= S_SCAN;
            K_ALL_OFF: begin
              keys_cnt_q <= 8'd0; clr_q <= 7'd0; state_q <= S_CLR;
            end
            K_ADVANCE: begin
              grace_left_q <= (grace_left_q > q_event_i.sample_count) ?
                              grace_left_q - q_event_i.sample_count : 16'd0;
            end
            K_FINISHED: begin
              if (32'(q_event_i.finished_voice) < VOICES)
                mode_q[VW'(q_event_i.finished_voice)] <= M_IDLE;
            end
            default: ;
          endcase
        end
        // one key cleared per cycle
        S_CLR: begin
          clr_q <= clr_q + 7'd1;
          if (clr_q == 7'(KEYS - 1)) begin
            boot_q <= 1'b0;
            state_q <= boot_q ? S_IDLE : S_SCAN;
          end
        end
        // held-key count follows the map
        S_KEY: begin
          if (ev_q.kind == K_NOTE_ON && !kd_q) keys_cnt_q <= keys_cnt_q + 8'd1;
          else if (ev_q.kind == K_NOTE_OFF && kd_q) keys_cnt_q <= keys_cnt_q - 8'd1;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (act) begin
            mode_q[vi_q] <= nmode;
            pend_q <= '{action: acode, voice: 3'(vi_q), out_note: anote,
                        stolen: 1'b0, detune: 16'd0, fire_single: 1'b0, last: 1'b0};
            has_res_q <= 1'b1;
            state_q <= S_WAIT;
          end else state_q <= S_NEXT;
        end
        S_WAIT: if (out_free) state_q <= S_NEXT;
        S_NEXT: begin
          if (!last_vi) begin
            vi_q <= vi_q + VW'(1); state_q <= S_SCAN;
          end else if (ev_q.kind == K_NOTE_ON) begin
            s_q <= ucl; i_q <= '0;
            vi_q <= '0; best_q <= '0; found_idle_q <= 1'b0; best_age_q <= age_q[0];
            state_q <= S_PICK;
          end else if (!has_res_q || out_free) state_q <= S_IDLE;
        end
        S_PICK: begin
          // first idle, else oldest (lowest on tie)
          if (!found_idle_q) begin
            if (mode_q[vi_q] == M_IDLE) begin
              found_idle_q <= 1'b1; best_q <= vi_q;
            end else if (age_q[vi_q] < best_age_q) begin
              best_q <= vi_q; best_age_q <= age_q[vi_q];
            end
          end
          if (last_vi || (!found_idle_q && mode_q[vi_q] == M_IDLE)) state_q <= S_DIV_SET;
          else vi_q <= vi_q + VW'(1);
        end
        S_DIV_SET: begin
          dneg_q <= mult[10];
          dnum_q <= 24'(ev_q.detune_spread) *
                    24'(mult[10] ? 11'(-mult) : 11'(mult));
          dden_q <= 9'({s_q - SW'(1), 1'b0});
          drem_q <= '0; dquo_q <= '0; dcnt_q <= '0;
          state_q <= (s_q == SW'(1)) ? S_START : S_DIV;
        end
        S_DIV: begin
          // restoring divide, one bit a cycle
          if (!dtrial[24]) begin
            drem_q <= dtrial; dquo_q <= {dquo_q[14:0], 1'b1};
          end else begin
            drem_q <= {drem_q[23:0], dnum_q[23]}; dquo_q <= {dquo_q[14:0], 1'b0};
          end
          dnum_q <= {dnum_q[22:0], 1'b0};
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd23) state_q <= S_START;
        end
        S_START: if (out_free) begin
          pend_q <= '{action: A_START, voice: 3'(best_q), out_note: ev_q.note,
                      stolen: (mode_q[best_q] != M_IDLE),
                      detune: (s_q == SW'(1)) ? 16'd0 : (dneg_q ? 16'(-dquo_q) : dquo_q),
                      fire_single: fire_q, last: 1'b0};
          has_res_q <= 1'b1;
          mode_q[best_q] <= M_PLAY;
          key_q[best_q] <= ev_q.note;
          age_ctr_q <= age_ctr_q + 32'd1;
          age_q[best_q] <= age_ctr_q + 32'd1;
          i_q <= i_q + SW'(1);
          best_q <= '0; found_idle_q <= 1'b0;
          if (i_q + SW'(1) == s_q) begin
            vi_q <= VW'(VOICES - 1);
            ev_q.kind <= K_ADVANCE; // drain pending as last
            state_q <= S_NEXT;
          end else begin
            vi_q <= '0;
            best_age_q <= (best_q == '0) ? age_ctr_q + 32'd1 : age_q[0];
            state_q <= S_PICK;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  idle_ready_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> out_v_q && $stable(res_q)) else $error("result dropped");
  start_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START && (!out_v_q || out_ready_i)) |=> mode_q[$past(best_q)] == M_PLAY)
    else $error("start did not claim voice");

endmodule

@@ hw/rtl/poly_voice_allocator.sv @@
// Polyphonic voice allocator. Each event word on the slave stream (kind in tuser)
// produces zero or more voice action words on the master stream, at most 2*VOICES,
// with tlast on the final one; events with nothing to act on produce none. Events are
// handled one at a time behind a two-word input queue. After reset the 128-entry
// held-key map is cleared before the first event is taken; all notes off runs the
// same clear before its release scan. In the back end an event is accepted, note on
// and note off then update the held-key map, and the release scan visits each voice
// slot in turn, with a wait step for a slot that emits an action. A note on then runs,
// per unison voice, the free/oldest search, a setup step, the detune division when the
// stack is larger than one and the voice start, and at the end hands out its final
// action. Advance, voice finished and unused kinds are handled at acceptance. Any step
// that hands out an action waits while the output register stays full. The one config
// register is the percussion grace window length in samples.
// Depends on pva_pkg, pva_front, pva_back.
`timescale 1ns / 1ps
module poly_voice_allocator import pva_pkg::*; #(
  parameter int unsigned VOICES = VOICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: note[6:0] pedal_down[7] unison_count[15:8] detune_spread[31:16]
  //        sample_count[47:32] finished_voice[50:48]
  input  logic [55:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: action[1:0] voice[4:2] out_note[11:5] stolen[12] detune[28:13] fire_single[29]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  event_t  in_ev, q_ev;
  logic    q_valid, q_ready;
  result_t res;

  assign in_ev = '{kind: s_axis_tuser, note: s_axis_tdata[6:0],
                   pedal_down: s_axis_tdata[7], unison_count: s_axis_tdata[15:8],
                   detune_spread: s_axis_tdata[31:16], sample_count: s_axis_tdata[47:32],
                   finished_voice: s_axis_tdata[50:48]};

  pva_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_event_i(in_ev),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_event_o(q_ev)
  );

  pva_back #(.VOICES(VOICES)) u_back (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_data_i(cfg_wdata_i),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_event_i(q_ev),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_result_o(res)
  );

  assign m_axis_tdata = {2'b00, res.fire_single, res.detune, res.stolen,
                         res.out_note, res.voice, res.action};
  assign m_axis_tlast = res.last;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for poly_voice_allocator: event stream in, voice actions out.
// Depends on pva_pkg and the poly_voice_allocator RTL.
`timescale 1ns / 1ps
module tb import pva_pkg::*; ();

  localparam int NV = 8;
  localparam longint CYCLE_LIMIT = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  poly_voice_allocator i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always #4 clk_i = ~clk_i;

  // Allocator state mirror
  logic [1:0]  vmode [NV];
  logic [6:0]  vkey [NV];
  logic [31:0] vage [NV];
  logic [31:0] age_ctr;
  logic        held [128];
  int          held_cnt;
  logic [15:0] grace_len;
  logic [15:0] grace_cnt;

  event_t  pending_words[$];
  result_t voice_actions[$];
  event_t  cur_ev;
  int      errors = 0;
  bit      hold_req = 1'b0;
  bit      hold_taken = 1'b0;
  int      hold_left = 0;
  longint  cycles = 0;

  function automatic void push_action(logic [1:0] act, int v, logic [6:0] key,
                                      logic stl, logic [15:0] det, logic fire);
    result_t r;
    r = '{act, v[2:0], key, stl, det, fire, 1'b0};
    voice_actions.push_back(r);
  endfunction

  function automatic bit is_sounding(int v);
    return vmode[v] == M_PLAY || vmode[v] == M_SUST;
  endfunction

  function automatic int choose_voice();
    int best;
    for (int v = 0; v < NV; v++) if (vmode[v] == M_IDLE) return v;
    best = 0;
    for (int v = 1; v < NV; v++) if (vage[v] < vage[best]) best = v;
    return best;
  endfunction

  // Apply one event to the mirror and queue the actions it causes
  function automatic void allocate_event(event_t e);
    int n0, s, v;
    logic fire;
    longint num, den, q;
    n0 = voice_actions.size();
    case (e.kind)
      K_NOTE_ON: begin
        if (held_cnt == 0) grace_cnt = grace_len;
        fire = grace_cnt != 0;
        if (!held[e.note]) begin
          held[e.note] = 1'b1;
          held_cnt++;
        end
        for (v = 0; v < NV; v++)
          if (is_sounding(v) && vkey[v] == e.note) begin
            vmode[v] = M_REL;
            push_action(A_RELEASE, v, e.note, 1'b0, '0, 1'b0);
          end
        s = e.unison_count;
        if (s < 1) s = 1;
        if (s > NV) s = NV;
        for (int i = 0; i < s; i++) begin
          v = choose_voice();
          q = 0;
          if (s > 1) begin
            num = longint'(e.detune_spread) * (2 * i - (s - 1));
            den = 2 * (s - 1);
            q = num / den;
          end
          push_action(A_START, v, e.note, vmode[v] != M_IDLE, q[15:0], fire);
          vmode[v] = M_PLAY;
          vkey[v] = e.note;
          age_ctr = age_ctr + 1;
          vage[v] = age_ctr;
        end
      end
      K_NOTE_OFF: begin
        if (held[e.note]) begin
          held[e.note] = 1'b0;
          held_cnt--;
        end
        for (v = 0; v < NV; v++)
          if (is_sounding(v) && vkey[v] == e.note) begin
            if (e.pedal_down) begin
              if (vmode[v] == M_PLAY) begin
                vmode[v] = M_SUST;
                push_action(A_HOLD, v, e.note, 1'b0, '0, 1'b0);
              end
            end else begin
              vmode[v] = M_REL;
              push_action(A_RELEASE, v, e.note, 1'b0, '0, 1'b0);
            end
          end
      end
      K_PEDAL: begin
        for (v = 0; v < NV; v++)
          if (vmode[v] == M_SUST) begin
            vmode[v] = M_REL;
            push_action(A_REL_SUST, v, vkey[v], 1'b0, '0, 1'b0);
          end
      end
      K_ALL_OFF: begin
        for (int k = 0; k < 128; k++) held[k] = 1'b0;
        held_cnt = 0;
        for (v = 0; v < NV; v++)
          if (is_sounding(v)) begin
            vmode[v] = M_REL;
            push_action(A_RELEASE, v, vkey[v], 1'b0, '0, 1'b0);
          end
      end
      K_ADVANCE: grace_cnt = grace_cnt > e.sample_count ? grace_cnt - e.sample_count : '0;
      K_FINISHED: vmode[e.finished_voice] = M_IDLE;
      default: ;
    endcase
    if (voice_actions.size() > n0) voice_actions[$].last = 1'b1;
  endfunction

  function automatic event_t make_event(logic [2:0] k, logic [6:0] n, logic p,
                                        logic [7:0] u, logic [15:0] sp,
                                        logic [15:0] sc, logic [2:0] f);
    event_t e;
    e = '{k, n, p, u, sp, sc, f};
    return e;
  endfunction

  // tdata layout of one event word, kind travels in tuser
  function automatic logic [55:0] pack_tdata(event_t e);
    return {5'd0, e.finished_voice, e.sample_count, e.detune_spread,
            e.unison_count, e.pedal_down, e.note};
  endfunction

  function automatic event_t random_event();
    int r;
    logic [2:0] k;
    logic [7:0] u;
    r = $urandom_range(99);
    if (r < 35) k = K_NOTE_ON;
    else if (r < 60) k = K_NOTE_OFF;
    else if (r < 68) k = K_PEDAL;
    else if (r < 71) k = K_ALL_OFF;
    else if (r < 82) k = K_ADVANCE;
    else if (r < 96) k = K_FINISHED;
    else k = 3'($urandom_range(7));
    u = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    // narrow key range so notes collide often; sometimes full range
    return make_event(k, ($urandom_range(3) == 0) ? 7'($urandom) : 7'(60 + $urandom_range(7)),
                      1'($urandom), u, 16'($urandom), 16'($urandom_range(2000)),
                      3'($urandom));
  endfunction

  // Driver: bursts with random gaps
  int gap = 0;
  always @(posedge clk_i) begin
    event_t e;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        allocate_event(cur_ev);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap > 0 || pending_words.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap > 0) gap <= gap - 1;
        end else begin
          e = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pack_tdata(e);
          s_axis_tuser <= e.kind;
          cur_ev <= e;
          if ($urandom_range(5) == 0) gap <= $urandom_range(12);
        end
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold-off counted here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= 3000;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(3) != 0 || cycles[9];
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    result_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[1:0], m_axis_tdata[4:2], m_axis_tdata[11:5], m_axis_tdata[12],
              m_axis_tdata[28:13], m_axis_tdata[29], m_axis_tlast};
      if (voice_actions.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, got);
        errors++;
      end else begin
        want = voice_actions.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected act=%0d v=%0d n=%0d st=%0d det=%0d f=%0d l=%0d",
                   $time, want.action, want.voice, want.out_note, want.stolen,
                   $signed(want.detune), want.fire_single, want.last);
          $display("%0t:          actual   act=%0d v=%0d n=%0d st=%0d det=%0d f=%0d l=%0d",
                   $time, got.action, got.voice, got.out_note, got.stolen,
                   $signed(got.detune), got.fire_single, got.last);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || s_axis_tvalid || voice_actions.size() != 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_grace(logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    grace_len = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    for (int v = 0; v < NV; v++) begin
      vmode[v] = M_IDLE; vkey[v] = '0; vage[v] = '0;
    end
    for (int k = 0; k < 128; k++) held[k] = 1'b0;
    age_ctr = '0; held_cnt = 0; grace_len = GRACE_RESET; grace_cnt = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, stealing, pedal, grace edges, unused kinds
    pending_words.push_back(make_event(K_NOTE_ON, 7'd0, 1'b0, 8'd0, 16'hFFFF, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_NOTE_ON, 7'd127, 1'b0, 8'd255, 16'hFFFF, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_NOTE_ON, 7'd127, 1'b0, 8'd3, 16'd1000, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_NOTE_ON, 7'd64, 1'b0, 8'd2, 16'd1, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_NOTE_OFF, 7'd127, 1'b1, 8'd0, 16'd0, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_NOTE_OFF, 7'd127, 1'b1, 8'd0, 16'd0, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_NOTE_OFF, 7'd5, 1'b0, 8'd0, 16'd0, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_PEDAL, 7'd0, 1'b0, 8'd0, 16'd0, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_PEDAL, 7'd0, 1'b0, 8'd0, 16'd0, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_ADVANCE, 7'd0, 1'b0, 8'd0, 16'd0, 16'hFFFF, 3'd0));
    pending_words.push_back(make_event(K_NOTE_ON, 7'd10, 1'b0, 8'd7, 16'd3, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_NOTE_OFF, 7'd64, 1'b0, 8'd0, 16'd0, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_ALL_OFF, 7'd0, 1'b0, 8'd0, 16'd0, 16'd0, 3'd0));
    pending_words.push_back(make_event(K_ALL_OFF, 7'd0, 1'b0, 8'd0, 16'd0, 16'd0, 3'd0));
    for (int v = 0; v < NV; v++)
      pending_words.push_back(make_event(K_FINISHED, 7'd0, 1'b0, 8'd0, 16'd0, 16'd0, 3'(v)));
    pending_words.push_back(make_event(3'd6, 7'h55, 1'b1, 8'hAA, 16'h5555, 16'hAAAA, 3'd2));
    pending_words.push_back(make_event(3'd7, 7'h2A, 1'b0, 8'h55, 16'hAAAA, 16'h5555, 3'd5));
    pending_words.push_back(make_event(K_ADVANCE, 7'd0, 1'b0, 8'd0, 16'd0, 16'd0, 3'd0));
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++)
      pending_words.push_back(make_event(K_NOTE_ON, 7'(i), 1'b0, 8'd8, 16'($urandom),
                                         16'd0, 3'd0));
    wait_drained();

    // Random phases under several grace settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_grace(16'd0);
        1: write_grace(16'hFFFF);
        2: write_grace(16'd1);
        default: write_grace(16'($urandom_range(3000)));
      endcase
      for (int i = 0; i < 75; i++) pending_words.push_back(random_event());
      wait_drained();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/pva_pkg.sv
hw/rtl/pva_front.sv
hw/rtl/pva_back.sv
hw/rtl/poly_voice_allocator.sv
tb/tb.sv
